// ----- design/ssmp_pkg.sv -----
// Shared types and constants for the servo smooth-move profiler.
// No dependencies; every other design file refers to this package by scoped name.
package ssmp_pkg;

   localparam int ANGLE_W   = 17;
   localparam int SPEED_W   = 18;
   localparam int RATE_W    = 16;
   localparam int CFG_W     = 12;
   localparam int PULSE_W   = 13;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Pulse mapping: divide by 180 through a reciprocal plus one correction step.
   localparam int DEG_FULL    = 180;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP       = (1 << RECIP_SHIFT) / DEG_FULL;
   localparam int RECIP_W     = 21;
   localparam int X_W         = 20;
   localparam int Q_W         = 13;
   localparam int QM_W        = X_W + RECIP_W;

   localparam logic [CFG_W-1:0] MIN_PULSE_RST   = 12'd544;
   localparam logic [CFG_W-1:0] PULSE_RANGE_RST = 12'd1856;

   localparam logic [OP_W-1:0] OP_DIRECT = 2'd0;
   localparam logic [OP_W-1:0] OP_START  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_RANGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE     = 2'd2;

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_START,
      KIND_TICK,
      KIND_IGNORE
   } ssmp_kind_type;

   typedef struct packed {
      ssmp_kind_type               kind;
      logic signed [ANGLE_W-1:0]   angle;
      logic [RATE_W-1:0]           speed_limit;
      logic [RATE_W-1:0]           accel;
   } ssmp_cmd_type;

   typedef struct packed {
      logic         valid;
      ssmp_cmd_type cmd;
   } ssmp_head_type;

   typedef struct packed {
      logic                      valid;
      logic                      written;
      logic                      moving;
      logic signed [ANGLE_W-1:0] position;
   } ssmp_step_type;

   typedef struct packed {
      logic [CFG_W-1:0] min_pulse;
      logic [CFG_W-1:0] pulse_range;
      logic             reverse;
   } ssmp_cfg_type;

endpackage

// ----- design/ssmp_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on ssmp_pkg for field widths.
interface ssmp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ssmp_pkg::OP_W-1:0]            operation;
   logic signed [ssmp_pkg::ANGLE_W-1:0]  angle_value;
   logic [ssmp_pkg::RATE_W-1:0]          speed_limit_in;
   logic [ssmp_pkg::RATE_W-1:0]          accel_in;

   modport source (output valid, operation, angle_value, speed_limit_in, accel_in,
                   input ready);
   modport sink (input valid, operation, angle_value, speed_limit_in, accel_in,
                 output ready);
endinterface

interface ssmp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ssmp_pkg::PULSE_W-1:0]         pulse_us;
   logic                                 pulse_written;
   logic                                 moving;
   logic signed [ssmp_pkg::ANGLE_W-1:0]  position_now;

   modport source (output valid, pulse_us, pulse_written, moving, position_now,
                   input ready);
   modport sink (input valid, pulse_us, pulse_written, moving, position_now,
                 output ready);
endinterface

// ----- design/servo_smooth_move_profiler_unit.sv -----
// Top level of the servo smooth-move profiler: front queue, motion update, pulse mapper.
// Depends on ssmp_pkg, ssmp_if, ssmp_front, ssmp_motion and ssmp_pulse.
//
//  Port group   Direction  Handshake          Content
//  req_if       in         valid/ready        operation, angle, speed limit, accel
//  rsp_if       out        valid/ready        pulse width, written flag, moving, position
//  csr_*        in         write enable only  min pulse, pulse range, reverse
//
// One item per cycle sustained while the response is not stalled; the motion state
// update closes its loop through its own state registers. Response valid follows the
// queue write at the accepting edge, then state update, range product, reciprocal
// product, correction into the response register. Synchronous reset; no clearing pass.
// A stalled response freezes the back end; the 4-entry queue takes items until full.
module servo_smooth_move_profiler_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   ssmp_req_if.sink                          req_if,
   ssmp_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [ssmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssmp_pkg::CFG_W-1:0]        csr_wdata
);

   ssmp_pkg::ssmp_cfg_type  cfg_ff, cfg_in;
   ssmp_pkg::ssmp_head_type head;
   ssmp_pkg::ssmp_step_type step;
   logic                    pop;
   logic                    advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ssmp_pkg::CSR_MIN_PULSE:   cfg_in.min_pulse   = csr_wdata;
            ssmp_pkg::CSR_PULSE_RANGE: cfg_in.pulse_range = csr_wdata;
            ssmp_pkg::CSR_REVERSE:     cfg_in.reverse     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse   <= ssmp_pkg::MIN_PULSE_RST;
         cfg_ff.pulse_range <= ssmp_pkg::PULSE_RANGE_RST;
         cfg_ff.reverse     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssmp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .pop    (pop),
      .head   (head)
   );

   ssmp_motion u_motion (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .advance (advance),
      .pop     (pop),
      .step    (step)
   );

   ssmp_pulse #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pulse (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (step),
      .advance (advance),
      .rsp_if  (rsp_if)
   );

`ifndef SYNTHESIS
   a_no_pulse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.pulse_written |-> rsp_if.pulse_us == '0)
      else $error("pulse width not zero on an item without a pulse");

   a_pulse_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.pulse_written |->
         rsp_if.pulse_us >= ssmp_pkg::PULSE_W'(cfg_ff.min_pulse) &&
         rsp_if.pulse_us <= ssmp_pkg::PULSE_W'(cfg_ff.min_pulse)
                          + ssmp_pkg::PULSE_W'(cfg_ff.pulse_range))
      else $error("pulse width outside min .. min + range");

   a_stall_freezes_back: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> $stable(step.valid))
      else $error("back end moved while the response was stalled");
`endif

endmodule

// ----- design/ssmp_front.sv -----
// Front end: accepts request items, decodes the operation and queues them.
// Depends on ssmp_pkg and ssmp_req_if.
module ssmp_front (
   input  logic                    clock,
   input  logic                    reset,
   ssmp_req_if.sink                req_if,
   input  logic                    pop,
   output ssmp_pkg::ssmp_head_type head
);

   ssmp_pkg::ssmp_cmd_type       queue_ff [ssmp_pkg::QUEUE_DEPTH];
   logic [ssmp_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ssmp_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ssmp_pkg::QPTR_W:0]    count_ff, count_in;
   logic                         push;
   ssmp_pkg::ssmp_cmd_type       decoded;

   assign req_if.ready = (count_ff != (ssmp_pkg::QPTR_W+1)'(ssmp_pkg::QUEUE_DEPTH));
   assign push = req_if.valid && req_if.ready;

   always_comb begin
      decoded.angle       = req_if.angle_value;
      decoded.speed_limit = req_if.speed_limit_in;
      decoded.accel       = req_if.accel_in;
      unique case (req_if.operation)
         ssmp_pkg::OP_DIRECT: decoded.kind = ssmp_pkg::KIND_DIRECT;
         ssmp_pkg::OP_START:  decoded.kind = ssmp_pkg::KIND_START;
         ssmp_pkg::OP_TICK:   decoded.kind = ssmp_pkg::KIND_TICK;
         default:             decoded.kind = ssmp_pkg::KIND_IGNORE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

// ----- design/ssmp_motion.sv -----
// Back end, first part: motion state and the per-item update of the profile.
// Depends on ssmp_pkg; feeds ssmp_pulse through a registered step.
module ssmp_motion (
   input  logic                    clock,
   input  logic                    reset,
   input  ssmp_pkg::ssmp_head_type head,
   input  logic                    advance,
   output logic                    pop,
   output ssmp_pkg::ssmp_step_type step
);

   localparam int AW = ssmp_pkg::ANGLE_W;
   localparam int SW = ssmp_pkg::SPEED_W;

   logic signed [AW-1:0]       cur_ff, cur_in, start_ff, start_in, goal_ff, goal_in;
   logic signed [SW-1:0]       speed_ff, speed_in;
   logic [ssmp_pkg::RATE_W-1:0] speed_cap_ff, speed_cap_in;
   logic [ssmp_pkg::RATE_W-1:0] step_accel_ff, step_accel_in;
   logic                       motion_ff, motion_in;
   logic                       written;
   ssmp_pkg::ssmp_step_type    step_ff;

   logic signed [AW+1:0] mid_lhs, mid_rhs;
   logic signed [SW:0]   accel_s, cap_s, spd_sum, spd_ext, applied;
   logic signed [SW-1:0] spd_sat;
   logic signed [AW+1:0] pos_sum;
   logic signed [AW-1:0] pos_sat;
   logic                 up, stop;

   assign pop = head.valid && advance;

   // Tick datapath
   always_comb begin
      mid_lhs = {cur_ff[AW-1], cur_ff, 1'b0};
      mid_rhs = (AW+2)'(start_ff) + (AW+2)'(goal_ff);
      accel_s = $signed({3'b000, step_accel_ff});
      cap_s   = $signed({3'b000, speed_cap_ff});
      if (mid_lhs < mid_rhs) begin
         spd_sum = (SW+1)'(speed_ff) + accel_s;
      end else begin
         spd_sum = (SW+1)'(speed_ff) - accel_s;
      end
      if (spd_sum[SW] != spd_sum[SW-1]) begin
         spd_sat = spd_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         spd_sat = spd_sum[SW-1:0];
      end
      spd_ext = (SW+1)'(spd_sat);
      if (spd_ext > cap_s) begin
         applied = cap_s;
      end else if (spd_ext < -cap_s) begin
         applied = -cap_s;
      end else begin
         applied = spd_ext;
      end
      pos_sum = (AW+2)'(cur_ff) + (AW+2)'(applied);
      if (pos_sum[AW+1:AW-1] == 3'b000 || pos_sum[AW+1:AW-1] == 3'b111) begin
         pos_sat = pos_sum[AW-1:0];
      end else begin
         pos_sat = pos_sum[AW+1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end
      up   = (start_ff < goal_ff);
      stop = up ? (spd_sat <= 0) : (spd_sat >= 0);
   end

   always_comb begin
      cur_in        = cur_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      speed_in      = speed_ff;
      speed_cap_in  = speed_cap_ff;
      step_accel_in = step_accel_ff;
      motion_in     = motion_ff;
      written       = 1'b0;
      unique case (head.cmd.kind)
         ssmp_pkg::KIND_DIRECT: begin
            cur_in  = head.cmd.angle;
            written = 1'b1;
         end
         ssmp_pkg::KIND_START: begin
            if (cur_ff == head.cmd.angle) begin
               motion_in = 1'b0;
            end else begin
               motion_in     = 1'b1;
               start_in      = cur_ff;
               goal_in       = head.cmd.angle;
               speed_in      = '0;
               speed_cap_in  = head.cmd.speed_limit;
               step_accel_in = head.cmd.accel;
            end
         end
         ssmp_pkg::KIND_TICK: begin
            if (motion_ff) begin
               speed_in = spd_sat;
               cur_in   = pos_sat;
               written  = 1'b1;
               if (stop) begin
                  motion_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         start_ff      <= '0;
         goal_ff       <= '0;
         speed_ff      <= '0;
         speed_cap_ff  <= '0;
         step_accel_ff <= '0;
         motion_ff     <= 1'b0;
      end else if (pop) begin
         cur_ff        <= cur_in;
         start_ff      <= start_in;
         goal_ff       <= goal_in;
         speed_ff      <= speed_in;
         speed_cap_ff  <= speed_cap_in;
         step_accel_ff <= step_accel_in;
         motion_ff     <= motion_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (advance) begin
         step_ff.valid <= pop;
      end
      if (pop) begin
         step_ff.written  <= written;
         step_ff.moving   <= motion_in;
         step_ff.position <= cur_in;
      end
   end

   assign step = step_ff;

endmodule

// ----- design/ssmp_pulse.sv -----
// Back end, second part: angle to pulse-width mapping pipeline and response register.
// Depends on ssmp_pkg and ssmp_rsp_if; takes steps from ssmp_motion.
module ssmp_pulse #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssmp_pkg::ssmp_cfg_type  cfg,
   input  ssmp_pkg::ssmp_step_type step,
   output logic                    advance,
   ssmp_rsp_if.source              rsp_if
);

   localparam int FULL   = ssmp_pkg::DEG_FULL << FRAC_BITS;
   localparam int D_W    = $clog2(FULL + 1);
   localparam int RW     = ((D_W > ssmp_pkg::ANGLE_W) ? D_W : ssmp_pkg::ANGLE_W) + 2;
   localparam int PROD_W = ssmp_pkg::CFG_W + D_W;

   logic signed [RW-1:0]          a_ext, full_s, rev;
   logic [D_W-1:0]                d;
   logic [PROD_W-1:0]             prod_in;
   logic [ssmp_pkg::X_W-1:0]      x_in;
   logic [ssmp_pkg::QM_W-1:0]     qm_in;
   logic [ssmp_pkg::Q_W-1:0]      q0, q;
   logic [ssmp_pkg::X_W-1:0]      r;
   logic [ssmp_pkg::PULSE_W-1:0]  pulse_in;

   // stage 2: product, stage 3: reciprocal product, then response register
   ssmp_pkg::ssmp_step_type       s2_ff, s3_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [ssmp_pkg::X_W-1:0]      x_ff;
   logic [ssmp_pkg::QM_W-1:0]     qm_ff;
   logic                          out_valid_ff;
   logic [ssmp_pkg::PULSE_W-1:0]  pulse_us_ff;
   logic                          written_ff, moving_ff;
   logic signed [ssmp_pkg::ANGLE_W-1:0] position_ff;

   assign advance = !out_valid_ff || rsp_if.ready;

   always_comb begin
      a_ext  = RW'(step.position);
      full_s = RW'(FULL);
      rev    = cfg.reverse ? full_s - a_ext : a_ext;
      if (rev < 0) begin
         d = '0;
      end else if (rev > full_s) begin
         d = D_W'(FULL);
      end else begin
         d = rev[D_W-1:0];
      end
      prod_in = PROD_W'(cfg.pulse_range) * PROD_W'(d);
   end

   always_comb begin
      x_in  = ssmp_pkg::X_W'(prod_ff >> FRAC_BITS);
      qm_in = ssmp_pkg::QM_W'(x_in) * ssmp_pkg::QM_W'(ssmp_pkg::RECIP);
   end

   // The reciprocal estimate is low by at most one.
   always_comb begin
      q0 = qm_ff[ssmp_pkg::RECIP_SHIFT +: ssmp_pkg::Q_W];
      r  = x_ff - ssmp_pkg::X_W'(q0 * ssmp_pkg::DEG_FULL);
      q  = (r >= ssmp_pkg::X_W'(ssmp_pkg::DEG_FULL)) ? q0 + 1'b1 : q0;
      pulse_in = s3_ff.written
               ? ssmp_pkg::PULSE_W'(cfg.min_pulse) + ssmp_pkg::PULSE_W'(q) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_ff.valid  <= step.valid;
         s3_ff.valid  <= s2_ff.valid;
         out_valid_ff <= s3_ff.valid;
      end
      if (advance) begin
         s2_ff.written  <= step.written;
         s2_ff.moving   <= step.moving;
         s2_ff.position <= step.position;
         prod_ff        <= prod_in;
         s3_ff.written  <= s2_ff.written;
         s3_ff.moving   <= s2_ff.moving;
         s3_ff.position <= s2_ff.position;
         x_ff           <= x_in;
         qm_ff          <= qm_in;
         pulse_us_ff    <= pulse_in;
         written_ff     <= s3_ff.written;
         moving_ff      <= s3_ff.moving;
         position_ff    <= s3_ff.position;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.pulse_us      = pulse_us_ff;
   assign rsp_if.pulse_written = written_ff;
   assign rsp_if.moving        = moving_ff;
   assign rsp_if.position_now  = position_ff;

endmodule
